// ----- hw/rtl/first_fit_extent_allocator_core_assert.svh -----
// Assertion macros of the allocator checker
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define FFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define FFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ----- hw/rtl/ffa_pkg.sv -----
// Shared types, codes and constants of the extent allocator
`default_nettype none
package ffa_pkg;

  localparam int MAX_EXTENTS_DEF = 64;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RESERVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_LIMIT   = 4'd1;
  localparam logic [3:0] ST_NOFIT   = 4'd2;
  localparam logic [3:0] ST_HEADER  = 4'd3;
  localparam logic [3:0] ST_TRAIL   = 4'd4;
  localparam logic [3:0] ST_LEAD    = 4'd5;
  localparam logic [3:0] ST_BEFORE  = 4'd6;
  localparam logic [3:0] ST_UNAVAIL = 4'd7;
  localparam logic [3:0] ST_FULL    = 4'd8;

  localparam logic [31:0] OFFSET_LIMIT = 32'h0100_0000;
  localparam logic [31:0] TOP_SECTOR   = 32'hFFFF_FFFF;
  localparam logic [7:0]  HDR_RESET    = 8'd16;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic init;
    logic found;
    logic advance;
    logic apply;
    logic read_up;
    logic read_dn;
    logic rem_step;
    logic rem_done;
    logic ins_step;
    logic ins_final;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_clear;
    logic req_zero;
    logic at_end;
    logic hit;
    logic plan_rem;
    logic plan_ins;
    logic rem_last;
    logic ins_here;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ffa_if.sv -----
// Request and response channel interfaces
`default_nettype none
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [23:0] offset;
  logic [7:0]  count;
  modport source (output valid, output mode, output offset, output count, input ready);
  modport sink (input valid, input mode, input offset, input count, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [23:0] result_offset;
  modport source (output valid, output status, output result_offset, input ready);
  modport sink (input valid, input status, input result_offset, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/first_fit_extent_allocator_core.sv -----
// Top level of the first-fit extent allocator
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | mode, offset, count
//  rsp     | out | valid/ready        | status, result_offset
//  cfg     | in  | cfg_we, no ready   | cfg_wdata = header_sectors
// One item at a time: the controller scans the table entries one by one, then
// shifts entries one by one on remove or insert, each through a read and a write state.
// The extent memory has one write port and one registered read port.
// After reset the INIT state writes the initial extent before req.ready rises.
// A waiting response does not block the next request; it blocks only the finish.
`default_nettype none
module first_fit_extent_allocator_core #(
  parameter int MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire  [7:0] cfg_wdata,
  ffa_req_if.sink    req,
  ffa_rsp_if.source  rsp
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffa_datapath #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_mode       (req.mode),
    .in_offset     (req.offset),
    .in_count      (req.count),
    .cmd           (cmd),
    .sts           (sts),
    .status        (rsp.status),
    .result_offset (rsp.result_offset)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/ffa_ctrl.sv -----
// Controller state machine of the extent allocator
`default_nettype none
module ffa_ctrl (
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire          out_ready,
  output logic         out_valid,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd
);
  import ffa_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CLR     = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_EVAL    = 4'd4;
  localparam logic [3:0] S_RESOLVE = 4'd5;
  localparam logic [3:0] S_REM     = 4'd6;
  localparam logic [3:0] S_REMW    = 4'd7;
  localparam logic [3:0] S_INS     = 4'd8;
  localparam logic [3:0] S_INSW    = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.req_clear) state_next = S_CLR;
          else if (sts.req_zero) state_next = S_DONE;
          else state_next = S_SCAN;
        end
      end
      S_CLR: begin
        cmd.init = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        state_next = sts.at_end ? S_RESOLVE : S_EVAL;
      end
      S_EVAL: begin
        if (sts.hit) begin
          cmd.found = 1'b1;
          state_next = S_RESOLVE;
        end else begin
          cmd.advance = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_RESOLVE: begin
        cmd.apply = 1'b1;
        if (sts.plan_rem) state_next = S_REM;
        else if (sts.plan_ins) state_next = S_INS;
        else state_next = S_DONE;
      end
      S_REM: begin
        if (sts.rem_last) begin
          cmd.rem_done = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.read_up = 1'b1;
          state_next = S_REMW;
        end
      end
      S_REMW: begin
        cmd.rem_step = 1'b1;
        state_next = S_REM;
      end
      S_INS: begin
        if (sts.ins_here) begin
          cmd.ins_final = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.read_dn = 1'b1;
          state_next = S_INSW;
        end
      end
      S_INSW: begin
        cmd.ins_step = 1'b1;
        state_next = S_INS;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ffa_datapath.sv -----
// Extent table, scan registers and request arithmetic
`default_nettype none
module ffa_datapath #(
  parameter int MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire  [7:0]   cfg_wdata,
  input  wire  [1:0]   in_mode,
  input  wire  [23:0]  in_offset,
  input  wire  [7:0]   in_count,
  input  ffa_pkg::cmd_t cmd,
  output ffa_pkg::sts_t sts,
  output logic [3:0]   status,
  output logic [23:0]  result_offset
);
  import ffa_pkg::*;

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int IW = $clog2(MAX_EXTENTS + 1);

  entry_t mem [MAX_EXTENTS];
  entry_t rd_q;
  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  entry_t          wr_data;

  logic [7:0]   hdr;
  logic [1:0]   mode_q;
  logic [23:0]  off_q;
  logic [7:0]   cnt_q;
  logic [IW-1:0] idx, total, pos;
  entry_t       prv, nxt, ins_d;
  logic         has_next;
  logic [3:0]   st_q;
  logic [23:0]  res_q;

  logic [31:0]  off32, c32;
  logic [32:0]  end33, prv_end;
  logic [IW-1:0] idx_up, idx_dn;
  logic [IW:0]  idx_up_w;
  logic         table_full;

  // resolve plan
  logic [3:0]    p_st;
  logic [23:0]   p_res;
  logic          p_wr, p_rem, p_ins;
  logic [AW-1:0] p_wa;
  entry_t        p_wd, p_ind;
  logic [IW-1:0] p_pos;

  assign off32      = {8'd0, off_q};
  assign c32        = {24'd0, cnt_q};
  assign end33      = {1'b0, off32} + {1'b0, c32};
  assign prv_end    = {1'b0, prv.start} + {1'b0, prv.len};
  assign idx_up     = idx + IW'(1);
  assign idx_dn     = idx - IW'(1);
  assign idx_up_w   = {1'b0, idx} + {{IW{1'b0}}, 1'b1};
  assign table_full = (total >= IW'(MAX_EXTENTS));

  always_comb begin
    p_st  = ST_OK;
    p_res = '0;
    p_wr  = 1'b0;
    p_rem = 1'b0;
    p_ins = 1'b0;
    p_wa  = idx[AW-1:0];
    p_wd  = nxt;
    p_ind = nxt;
    p_pos = idx;
    case (mode_q)
      MODE_ALLOC: begin
        if (!has_next) begin
          p_st = ST_NOFIT;
        end else if (nxt.start >= OFFSET_LIMIT) begin
          p_st = ST_LIMIT;
        end else begin
          p_res = nxt.start[23:0];
          if (nxt.len > c32) begin
            p_wr = 1'b1;
            p_wd.start = nxt.start + c32;
            p_wd.len   = nxt.len - c32;
          end else begin
            p_rem = 1'b1;
          end
        end
      end
      MODE_FREE: begin
        if (off32 < {24'd0, hdr}) begin
          p_st = ST_HEADER;
        end else if (has_next && (end33 > {1'b0, nxt.start})) begin
          p_st = ST_TRAIL;
        end else if ((idx != '0) && (prv_end > {1'b0, off32})) begin
          p_st = ST_LEAD;
        end else if (has_next && (end33 == {1'b0, nxt.start})) begin
          if ((idx != '0) && (prv_end == {1'b0, off32})) begin
            // bridge both neighbours, drop the upper one
            p_wr = 1'b1;
            p_wa = idx_dn[AW-1:0];
            p_wd.start = prv.start;
            p_wd.len   = prv.len + c32 + nxt.len;
            p_rem = 1'b1;
          end else begin
            p_wr = 1'b1;
            p_wd.start = off32;
            p_wd.len   = nxt.len + c32;
          end
        end else if ((idx != '0) && (prv_end == {1'b0, off32})) begin
          p_wr = 1'b1;
          p_wa = idx_dn[AW-1:0];
          p_wd.start = prv.start;
          p_wd.len   = prv.len + c32;
        end else if (table_full) begin
          p_st = ST_FULL;
        end else begin
          p_ins = 1'b1;
          p_ind.start = off32;
          p_ind.len   = c32;
        end
      end
      default: begin
        // reserve
        p_wa = idx_dn[AW-1:0];
        p_wd.start = prv.start;
        p_wd.len   = off32 - prv.start;
        if (idx == '0) begin
          p_st = ST_BEFORE;
        end else if (prv.start == off32) begin
          if (prv.len > c32) begin
            p_wr = 1'b1;
            p_wd.start = off32 + c32;
            p_wd.len   = prv.len - c32;
          end else if (prv.len < c32) begin
            p_st = ST_UNAVAIL;
          end else begin
            p_rem = 1'b1;
            p_pos = idx_dn;
          end
        end else if (prv_end < end33) begin
          p_st = ST_UNAVAIL;
        end else if (prv_end > end33) begin
          if (table_full) begin
            p_st = ST_FULL;
          end else begin
            // split: keep the head, insert the tail
            p_wr = 1'b1;
            p_ins = 1'b1;
            p_ind.start = end33[31:0];
            p_ind.len   = prv_end[31:0] - end33[31:0];
          end
        end else begin
          p_wr = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    sts.req_clear = (in_mode == MODE_CLEAR);
    sts.req_zero  = (in_count == 8'd0);
    sts.at_end    = (idx == total);
    sts.hit       = (mode_q == MODE_ALLOC) ? (rd_q.len >= c32) : (rd_q.start > off32);
    sts.plan_rem  = p_rem;
    sts.plan_ins  = p_ins;
    sts.rem_last  = (idx_up_w >= {1'b0, total});
    sts.ins_here  = (idx == pos);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_q;
    if (cmd.init) begin
      wr_en = 1'b1;
      wr_addr = '0;
      wr_data.start = {24'd0, hdr};
      wr_data.len   = TOP_SECTOR - {24'd0, hdr};
    end else if (cmd.apply) begin
      wr_en = p_wr;
      wr_addr = p_wa;
      wr_data = p_wd;
    end else if (cmd.rem_step || cmd.ins_step) begin
      wr_en = 1'b1;
    end else if (cmd.ins_final) begin
      wr_en = 1'b1;
      wr_addr = pos[AW-1:0];
      wr_data = ins_d;
    end
  end

  always_comb begin
    if (cmd.read_up) rd_addr = idx_up[AW-1:0];
    else if (cmd.read_dn) rd_addr = idx_dn[AW-1:0];
    else rd_addr = idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= HDR_RESET;
      total <= IW'(1);
      idx <= '0;
      has_next <= 1'b0;
    end else begin
      if (cfg_we) hdr <= cfg_wdata;
      if (cmd.accept) begin
        idx <= '0;
        has_next <= 1'b0;
      end
      if (cmd.init) total <= IW'(1);
      if (cmd.found) has_next <= 1'b1;
      if (cmd.advance || cmd.rem_step) idx <= idx_up;
      if (cmd.ins_step) idx <= idx_dn;
      if (cmd.apply) idx <= p_rem ? p_pos : total;
      if (cmd.rem_done) total <= total - IW'(1);
      if (cmd.ins_final) total <= total + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= in_mode;
      off_q  <= in_offset;
      cnt_q  <= in_count;
      st_q   <= ST_OK;
      res_q  <= '0;
    end
    if (cmd.found) nxt <= rd_q;
    if (cmd.advance) prv <= rd_q;
    if (cmd.apply) begin
      st_q  <= p_st;
      res_q <= p_res;
      pos   <= p_pos;
      ins_d <= p_ind;
    end
    if (cmd.load_out) begin
      status <= st_q;
      result_offset <= res_q;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ffa_checker.sv -----
// Port-level checker for the extent allocator, bound to the top level
`default_nettype none
`include "first_fit_extent_allocator_core_assert.svh"
module ffa_checker (
  input wire        clk,
  input wire        rst,
  input wire        req_valid,
  input wire        req_ready,
  input wire        rsp_valid,
  input wire        rsp_ready,
  input wire [3:0]  rsp_status,
  input wire [23:0] rsp_result_offset
);
  import ffa_pkg::*;

  `FFA_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready)
  `FFA_ASSERT_IMP(a_status_range, rsp_valid, rsp_status <= ST_FULL)
  `FFA_ASSERT_IMP(a_offset_zero, rsp_valid && (rsp_status != ST_OK), rsp_result_offset == 24'd0)
  `FFA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
endmodule

bind first_fit_extent_allocator_core ffa_checker u_ffa_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_result_offset (rsp.result_offset)
);
`default_nettype wire

// ----- tb/first_fit_extent_allocator_core_tb.sv -----
// Self-checking testbench of the first-fit extent allocator core
module first_fit_extent_allocator_core_tb;
  import ffa_pkg::*;

  localparam int NEXT = 64;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  ffa_req_if req ();
  ffa_rsp_if rsp ();

  first_fit_extent_allocator_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // free extent table of the predictor
  logic [31:0] fx_start [NEXT];
  logic [31:0] fx_len [NEXT];
  int unsigned fx_total;
  logic [7:0] hdr;

  typedef struct packed {
    logic [3:0]  status;
    logic [23:0] result_offset;
  } grant_t;

  grant_t grant_q[$];
  int errors = 0;
  longint cycles = 0;
  bit rsp_hold = 1'b0;
  bit quiet = 1'b0;

  logic [7:0] hdr_set [] = '{8'd1, 8'd255, 8'd0, 8'd16};

  function automatic void pool_clear();
    fx_start[0] = {24'd0, hdr};
    fx_len[0] = TOP_SECTOR - {24'd0, hdr};
    fx_total = 1;
  endfunction

  function automatic void ins(int unsigned pos, logic [31:0] s, logic [31:0] l);
    for (int unsigned i = fx_total; i > pos; i--) begin
      fx_start[i] = fx_start[i-1];
      fx_len[i] = fx_len[i-1];
    end
    fx_start[pos] = s;
    fx_len[pos] = l;
    fx_total++;
  endfunction

  function automatic void rem(int unsigned pos);
    for (int unsigned i = pos; i + 1 < fx_total; i++) begin
      fx_start[i] = fx_start[i+1];
      fx_len[i] = fx_len[i+1];
    end
    fx_total--;
  endfunction

  function automatic int unsigned above(logic [31:0] off);
    int unsigned i;
    i = 0;
    while (i < fx_total && fx_start[i] <= off) i++;
    return i;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] mode, logic [23:0] off,
                                           logic [7:0] cnt);
    grant_t g;
    int unsigned t;
    int unsigned l;
    logic [32:0] e;
    logic [32:0] pe;
    bit mn;
    bit mp;
    bit done;
    g = '0;
    mn = 0;
    mp = 0;
    done = 0;
    if (mode == MODE_CLEAR) begin
      pool_clear();
    end else if (cnt != 0) begin
      case (mode)
        MODE_ALLOC: begin
          g.status = ST_NOFIT;
          for (int unsigned i = 0; i < fx_total && !done; i++) begin
            if (fx_len[i] >= cnt) begin
              done = 1;
              if (fx_start[i] >= OFFSET_LIMIT) begin
                g.status = ST_LIMIT;
              end else begin
                g.status = ST_OK;
                g.result_offset = fx_start[i][23:0];
                if (fx_len[i] > cnt) begin
                  fx_start[i] = fx_start[i] + cnt;
                  fx_len[i] = fx_len[i] - cnt;
                end else begin
                  rem(i);
                end
              end
            end
          end
        end
        MODE_FREE: begin
          e = off + cnt;
          t = above({8'd0, off});
          if ({8'd0, off} < {24'd0, hdr}) g.status = ST_HEADER;
          else if (t < fx_total && e > fx_start[t]) g.status = ST_TRAIL;
          else begin
            if (t < fx_total && e == fx_start[t]) mn = 1;
            if (t > 0) begin
              pe = fx_start[t-1] + fx_len[t-1];
              if (pe == off) mp = 1;
              else if (pe > off) g.status = ST_LEAD;
            end
            if (g.status == ST_OK) begin
              if (mn && mp) begin
                fx_len[t-1] = fx_len[t-1] + cnt + fx_len[t];
                rem(t);
              end else if (mn) begin
                fx_start[t] = {8'd0, off};
                fx_len[t] = fx_len[t] + cnt;
              end else if (mp) begin
                fx_len[t-1] = fx_len[t-1] + cnt;
              end else if (fx_total >= NEXT) begin
                g.status = ST_FULL;
              end else begin
                ins(t, {8'd0, off}, {24'd0, cnt});
              end
            end
          end
        end
        default: begin
          t = above({8'd0, off});
          if (t == 0) begin
            g.status = ST_BEFORE;
          end else begin
            l = t - 1;
            if (fx_start[l] == off) begin
              if (fx_len[l] > cnt) begin
                fx_start[l] = off + cnt;
                fx_len[l] = fx_len[l] - cnt;
              end else if (fx_len[l] < cnt) g.status = ST_UNAVAIL;
              else rem(l);
            end else begin
              e = off + cnt;
              pe = fx_start[l] + fx_len[l];
              if (pe < e) g.status = ST_UNAVAIL;
              else if (pe > e && fx_total >= NEXT) g.status = ST_FULL;
              else begin
                if (pe > e) ins(t, e[31:0], 32'(pe - e));
                fx_len[l] = off - fx_start[l];
              end
            end
          end
        end
      endcase
    end
    return g;
  endfunction

  // valid stays high between back-to-back items; drop it only for an idle gap
  task automatic send(logic [1:0] mode, logic [23:0] off, logic [7:0] cnt);
    if (!quiet && $urandom_range(99) < 36) begin
      req.valid <= 1'b0;
      @(negedge clk);
      while (!quiet && $urandom_range(99) < 36) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.offset <= off;
    req.count <= cnt;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    grant_q.push_back(predict_grant(mode, off, cnt));
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_hdr(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hdr = v;
  endtask

  // response sink: random stalls, long hold when asked
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= !rsp_hold && (quiet || $urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    grant_t g;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (grant_q.size() == 0) begin
        $error("unexpected response status=%0d", rsp.status);
        errors++;
      end else begin
        g = grant_q.pop_front();
        if (rsp.status !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, rsp.status);
          errors++;
        end
        if (rsp.result_offset !== g.result_offset) begin
          $error("result_offset: expected %0h, got %0h", g.result_offset,
                 rsp.result_offset);
          errors++;
        end
      end
    end
  end

  typedef struct {
    logic [1:0]  mode;
    logic [23:0] off;
    logic [7:0]  cnt;
  } step_t;

  step_t plan [] = '{
    '{MODE_ALLOC, 24'd0, 8'd255}, '{MODE_ALLOC, 24'hFFFFFF, 8'd1},
    '{MODE_ALLOC, 24'd0, 8'd0}, '{MODE_FREE, 24'd3, 8'd4},
    '{MODE_FREE, 24'd16, 8'd255}, '{MODE_FREE, 24'd300, 8'd5},
    '{MODE_FREE, 24'd100, 8'd10}, '{MODE_FREE, 24'd200, 8'd10},
    '{MODE_FREE, 24'd50, 8'd50}, '{MODE_FREE, 24'd110, 8'd90},
    '{MODE_FREE, 24'd16, 8'd34}, '{MODE_RESERVE, 24'd0, 8'd5},
    '{MODE_RESERVE, 24'd16, 8'd4}, '{MODE_RESERVE, 24'd40, 8'd10},
    '{MODE_RESERVE, 24'd20, 8'd20}, '{MODE_RESERVE, 24'd60, 8'd255},
    '{MODE_RESERVE, 24'hFFFFFF, 8'd255}, '{MODE_ALLOC, 24'd0, 8'd200},
    '{MODE_CLEAR, 24'hABCDEF, 8'd7}, '{MODE_FREE, 24'hFFFFFF, 8'd0},
    '{MODE_RESERVE, 24'd16, 8'd0}
  };

  task automatic random_item(bit shaped);
    logic [1:0] m;
    logic [23:0] o;
    logic [7:0] c;
    m = 2'($urandom_range(3));
    if (m == MODE_CLEAR && $urandom_range(9) != 0) m = MODE_ALLOC;
    c = 8'($urandom_range(255));
    if ($urandom_range(19) == 0) c = 0;
    o = 24'($urandom);
    if (shaped) begin
      o = 24'($urandom_range(4000));
      if (m == MODE_ALLOC && $urandom_range(3) == 0) c = 8'($urandom_range(8));
    end
    send(m, o, c);
  endtask

  // push the allocation frontier past 2^24 so the offset limit shows
  task automatic climb();
    for (int i = 0; i < 40; i++) send(MODE_RESERVE, 24'hFFFF00, 8'd255);
    send(MODE_RESERVE, 24'($urandom_range(16, 255)), 8'd1);
    send(MODE_ALLOC, 24'd0, 8'd255);
  endtask

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_ALLOC;
    req.offset = '0;
    req.count = '0;
    hdr = HDR_RESET;
    pool_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send(plan[i].mode, plan[i].off, plan[i].cnt);
    drain();
    // fill the table to force table full
    send(MODE_CLEAR, 24'd0, 8'd0);
    for (int i = 0; i < 70; i++) send(MODE_RESERVE, 24'(20 + 3 * i), 8'd1);
    // hold the sink for a long stretch while requests keep coming
    rsp_hold = 1'b1;
    fork
      begin repeat (2000) @(negedge clk); rsp_hold = 1'b0; end
      for (int i = 0; i < 60; i++) random_item(1);
    join
    drain();
    foreach (hdr_set[k]) begin
      write_hdr(hdr_set[k]);
      send(MODE_CLEAR, 24'd0, 8'd0);
      send(MODE_FREE, 24'(hdr_set[k]) - 24'd1, 8'd1);
      if (k == 2) climb();
      quiet = (k == 1);
      for (int i = 0; i < 280; i++) random_item($urandom_range(9) != 0);
      quiet = 1'b0;
      drain();
    end
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
